@@ hdl/relative_rect_to_polar_assert.svh @@
// Assertion macros for the relative_rect_to_polar block.
`ifndef RELATIVE_RECT_TO_POLAR_ASSERT_SVH
`define RELATIVE_RECT_TO_POLAR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define RRP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrp: same-cycle check failed");

// next-cycle implication, quiet during reset
`define RRP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrp: next-cycle check failed");

`endif

@@ hdl/rrp_pkg.sv @@
// Package: constants, types and the arctangent table of the rect-to-polar block.
package rrp_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int ROTATION_STEPS_DEF = 16;
  localparam int CORDIC_W           = 62;
  localparam int FIXED_POINT_POS    = 58;
  localparam int ANGLE_W            = 32;
  localparam int DIST_W             = 17;
  localparam int ANGLE_OUT_W        = 16;

  localparam logic [ANGLE_W-1:0] ANGLE_HALF_TURN = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_ROUND     = 32'h0000_8000;

  typedef logic signed [CORDIC_W-1:0] cordic_val_t;

  typedef struct packed {
    cordic_val_t        x;
    cordic_val_t        y;
    logic [ANGLE_W-1:0] z;
    logic               zero;
  } cordic_t;

  function automatic logic [ANGLE_W-1:0] atan_entry(input int step);
    logic [ANGLE_W-1:0] val;
    case (step)
      0:  val = 32'h20000000;
      1:  val = 32'h12E4051E;
      2:  val = 32'h09FB385B;
      3:  val = 32'h051111D4;
      4:  val = 32'h028B0D43;
      5:  val = 32'h0145D7E1;
      6:  val = 32'h00A2F61E;
      7:  val = 32'h00517C55;
      8:  val = 32'h0028BE53;
      9:  val = 32'h00145F2F;
      10: val = 32'h000A2F98;
      11: val = 32'h000517CC;
      12: val = 32'h00028BE6;
      13: val = 32'h000145F3;
      14: val = 32'h0000A2FA;
      15: val = 32'h0000517D;
      16: val = 32'h000028BE;
      17: val = 32'h0000145F;
      18: val = 32'h00000A30;
      19: val = 32'h00000518;
      20: val = 32'h0000028C;
      21: val = 32'h00000146;
      22: val = 32'h000000A3;
      23: val = 32'h00000051;
      24: val = 32'h00000029;
      25: val = 32'h00000014;
      26: val = 32'h0000000A;
      27: val = 32'h00000005;
      28: val = 32'h00000003;
      29: val = 32'h00000001;
      30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/rrp_in_if.sv @@
// Interface: input channel carrying a point and a reference point.
interface rrp_in_if import rrp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;

  modport source (output valid, output point_x, output point_y, output ref_x, output ref_y,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input ref_x, input ref_y,
                output ready);
endinterface

@@ hdl/rrp_out_if.sv @@
// Interface: output channel carrying distance and angle.
interface rrp_out_if import rrp_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [DIST_W-1:0]             distance;
  logic signed [ANGLE_OUT_W-1:0] angle;

  modport source (output valid, output distance, output angle, input ready);
  modport sink (input valid, input distance, input angle, output ready);
endinterface

@@ hdl/rrp_front.sv @@
// Front end: difference vector, squares, sum of squares and CORDIC start values.
module rrp_front import rrp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  rrp_in_if.sink                     coords,
  output logic                       valid,
  input  logic                       ready,
  output logic [2*COORD_BITS+1:0]    sum_sq,
  output cordic_t                    cord
);
  localparam int DW   = COORD_BITS + 1;
  localparam int SW   = 2 * COORD_BITS + 2;
  localparam int FRAC = FIXED_POINT_POS - COORD_BITS;

  logic                 v1, v2, v3;
  logic                 rdy1, rdy2, rdy3;
  logic signed [DW-1:0] dx1, dy1;
  logic signed [DW-1:0] dx_next, dy_next;
  logic [SW-1:0]        sqx2, sqy2;
  logic [DW-1:0]        ax, ay;
  logic signed [DW-1:0] ndx, ndy;
  cordic_t              c2, c2_next;
  logic [SW-1:0]        sum3;
  cordic_t              c3;

  assign rdy3 = !v3 || ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign coords.ready = rdy1;

  assign dx_next = DW'(coords.point_x) - DW'(coords.ref_x);
  assign dy_next = DW'(coords.point_y) - DW'(coords.ref_y);

  always_comb begin
    ax = dx1[DW-1] ? DW'(-dx1) : DW'(dx1);
    ay = dy1[DW-1] ? DW'(-dy1) : DW'(dy1);
    ndx = dx1[DW-1] ? -dx1 : dx1;
    ndy = dx1[DW-1] ? -dy1 : dy1;
    c2_next.x    = CORDIC_W'(ndx) <<< FRAC;
    c2_next.y    = CORDIC_W'(ndy) <<< FRAC;
    c2_next.z    = dx1[DW-1] ? ANGLE_HALF_TURN : '0;
    c2_next.zero = (dx1 == '0) && (dy1 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= coords.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && coords.valid) begin
      dx1 <= dx_next;
      dy1 <= dy_next;
    end
    if (rdy2 && v1) begin
      sqx2 <= SW'(ax) * SW'(ax);
      sqy2 <= SW'(ay) * SW'(ay);
      c2   <= c2_next;
    end
    if (rdy3 && v2) begin
      sum3 <= sqx2 + sqy2;
      c3   <= c2;
    end
  end

  assign valid  = v3;
  assign sum_sq = sum3;
  assign cord   = c3;
endmodule

@@ hdl/rrp_cell.sv @@
// Chain cell: a square-root bit and/or a CORDIC micro-rotation, by index.
module rrp_cell import rrp_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF,
  parameter int IDX            = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    ready_up,
  input  logic                    ready_dn,
  input  logic [2*COORD_BITS+1:0] rem_in,
  input  logic [COORD_BITS:0]     root_in,
  input  cordic_t                 cord_in,
  output logic                    valid,
  output logic [2*COORD_BITS+1:0] rem,
  output logic [COORD_BITS:0]     root,
  output cordic_t                 cord
);
  localparam int SW = 2 * COORD_BITS + 2;
  localparam int RW = COORD_BITS + 1;
  localparam int TW = SW + 2;

  logic [SW-1:0] rem_next;
  logic [RW-1:0] root_next;
  cordic_t       cord_next;

  assign ready_up = !valid || ready_dn;

  generate
    if (IDX <= COORD_BITS) begin : g_sqrt
      localparam int B = COORD_BITS - IDX;
      localparam logic [TW-1:0] ONE_T = 1;
      localparam logic [RW-1:0] ONE_R = 1;
      logic [TW-1:0] trial;
      logic          take;
      always_comb begin
        trial = (TW'(root_in) << (B + 1)) | (ONE_T << (2 * B));
        take  = TW'(rem_in) >= trial;
        rem_next  = take ? SW'(TW'(rem_in) - trial) : rem_in;
        root_next = take ? (root_in | (ONE_R << B)) : root_in;
      end
    end else begin : g_sqrt_pass
      assign rem_next  = rem_in;
      assign root_next = root_in;
    end

    if (IDX < ROTATION_STEPS) begin : g_rot
      cordic_val_t cx, cy, xs, ys;
      always_comb begin
        cx = cord_in.x;
        cy = cord_in.y;
        xs = cx >>> IDX;
        ys = cy >>> IDX;
        cord_next.zero = cord_in.zero;
        if (!cy[CORDIC_W-1]) begin
          cord_next.x = cx + ys;
          cord_next.y = cy - xs;
          cord_next.z = cord_in.z + atan_entry(IDX);
        end else begin
          cord_next.x = cx - ys;
          cord_next.y = cy + xs;
          cord_next.z = cord_in.z - atan_entry(IDX);
        end
      end
    end else begin : g_rot_pass
      assign cord_next = cord_in;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && in_valid) begin
      rem  <= rem_next;
      root <= root_next;
      cord <= cord_next;
    end
  end
endmodule

@@ hdl/relative_rect_to_polar.sv @@
// Top level: relative rectangular-to-polar converter built as a chain of cells.
//
//   channel  role    carries
//   coords   sink    point_x, point_y, ref_x, ref_y (COORD_BITS each, signed)
//   polar    source  distance (17 bits), angle (16 bits signed, 32768 = pi)
//
// One transaction per cycle sustained while the output is not stalled. A
// transaction passes three front stages, a chain of cells that each add a
// root bit, a micro-rotation or both, and the output register.
// Every stage advances when its successor is free, so bubbles close up while
// the output is stalled. Synchronous reset clears only the valid bits.
`include "relative_rect_to_polar_assert.svh"

module relative_rect_to_polar import rrp_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  rrp_in_if.sink   coords,
  rrp_out_if.source polar
);
  localparam int SW = 2 * COORD_BITS + 2;
  localparam int RW = COORD_BITS + 1;
  localparam int N  = (COORD_BITS + 1 > ROTATION_STEPS) ? COORD_BITS + 1 : ROTATION_STEPS;

  logic          chain_valid [0:N];
  logic          chain_ready [0:N];
  logic [SW-1:0] rem_c       [0:N];
  logic [RW-1:0] root_c      [0:N];
  cordic_t       cord_c      [0:N];

  logic                          out_valid;
  logic [DIST_W-1:0]             out_distance;
  logic signed [ANGLE_OUT_W-1:0] out_angle;
  logic [ANGLE_W-1:0]            angle_sum;

  rrp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .coords (coords),
    .valid  (chain_valid[0]),
    .ready  (chain_ready[0]),
    .sum_sq (rem_c[0]),
    .cord   (cord_c[0])
  );

  assign root_c[0] = '0;

  generate
    for (genvar k = 0; k < N; k++) begin : g_chain
      rrp_cell #(
        .COORD_BITS     (COORD_BITS),
        .ROTATION_STEPS (ROTATION_STEPS),
        .IDX            (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .in_valid (chain_valid[k]),
        .ready_up (chain_ready[k]),
        .ready_dn (chain_ready[k+1]),
        .rem_in   (rem_c[k]),
        .root_in  (root_c[k]),
        .cord_in  (cord_c[k]),
        .valid    (chain_valid[k+1]),
        .rem      (rem_c[k+1]),
        .root     (root_c[k+1]),
        .cord     (cord_c[k+1])
      );
    end
  endgenerate

  assign chain_ready[N] = !out_valid || polar.ready;
  assign angle_sum = cord_c[N].z + ANGLE_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[N]) begin
      out_valid <= chain_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[N] && chain_valid[N]) begin
      out_distance <= DIST_W'(root_c[N]);
      out_angle    <= cord_c[N].zero ? '0 : angle_sum[ANGLE_W-1 -: ANGLE_OUT_W];
    end
  end

  assign polar.valid    = out_valid;
  assign polar.distance = out_distance;
  assign polar.angle    = out_angle;

  // zero vector stays at the origin through every rotation
  `RRP_ASSERT_IMP(a_zero_origin, chain_valid[N] && cord_c[N].zero, (cord_c[N].x == '0) && (cord_c[N].y == '0))
  // root leaving the chain is the floor: remainder never exceeds twice the root
  `RRP_ASSERT_IMP(a_root_floor, chain_valid[N], rem_c[N] <= (SW'(root_c[N]) << 1))
  // with the output register empty the whole chain can take a transaction
  `RRP_ASSERT_IMP(a_drain_ready, !out_valid, coords.ready)
  // a result not taken stays in the output register
  `RRP_ASSERT_NEXT(a_out_hold, out_valid && !polar.ready, out_valid)
endmodule

@@ tb/tb_top.sv @@
// Testbench for relative_rect_to_polar: queued stimulus, CORDIC predictor, scoreboard.
module tb_top import rrp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = COORD_BITS_DEF;
  localparam int STEPS      = ROTATION_STEPS_DEF;
  localparam int FRAC       = FIXED_POINT_POS - CW;
  localparam int RAND_ITEMS = 1850;
  localparam int CALM_TAIL  = 120;
  localparam int DRAIN_WAIT = 40;
  localparam int STALL_MAX  = 2000;

  localparam logic [ANGLE_W-1:0] ATAN_STEP [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
  } coord_t;

  typedef struct packed {
    logic [DIST_W-1:0]             distance;
    logic signed [ANGLE_OUT_W-1:0] angle;
  } polar_t;

  logic clk;
  logic rst;

  rrp_in_if #(.COORD_BITS(CW)) coords_ch ();
  rrp_out_if polar_ch ();

  relative_rect_to_polar #(
    .COORD_BITS(CW),
    .ROTATION_STEPS(STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .coords(coords_ch),
    .polar(polar_ch)
  );

  coord_t coord_backlog [$];
  polar_t pending_polar [$];
  int     fails       = 0;
  int     idle_cycles = 0;
  bit     in_taken    = 0;
  bit     jittery     = 1;
  int     in_gap      = 0;
  int     out_gap     = 0;

  function automatic polar_t calc_polar(coord_t c);
    longint             dx, dy, ax, ay, x, y, xs, ys;
    longint unsigned    sumsq, root, trial;
    logic [ANGLE_W-1:0] z, zr;
    polar_t             r;
    dx = longint'(c.px) - longint'(c.rx);
    dy = longint'(c.py) - longint'(c.ry);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sumsq = ax * ax + ay * ay;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sumsq) root = trial;
    end
    r.distance = root[DIST_W-1:0];
    if (dx == 0 && dy == 0) begin
      r.angle = '0;
      return r;
    end
    z = '0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      z = ANGLE_HALF_TURN;
    end
    x = dx <<< FRAC;
    y = dy <<< FRAC;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end
    end
    zr = z + ANGLE_ROUND;
    r.angle = zr[ANGLE_W-1:ANGLE_W-ANGLE_OUT_W];
    return r;
  endfunction

  task automatic add_item(input int px, input int py, input int rx, input int ry);
    coord_t c;
    c.px = CW'(px);
    c.py = CW'(py);
    c.rx = CW'(rx);
    c.ry = CW'(ry);
    coord_backlog.push_back(c);
  endtask

  function automatic logic signed [CW-1:0] corner_val();
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = -32768;
      1: v = -32767;
      2: v = -1;
      3: v = 0;
      4: v = 1;
      5: v = 32766;
      6: v = 32767;
      default: v = CW'($urandom_range(0, 3) - 2);
    endcase
    return v;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // sender: new transaction only once the previous one was taken
  always @(negedge clk) begin
    coord_t c;
    if ($urandom_range(0, 199) == 0) jittery = !jittery;
    if (rst) begin
      coords_ch.valid   <= 1'b0;
      coords_ch.point_x <= '0;
      coords_ch.point_y <= '0;
      coords_ch.ref_x   <= '0;
      coords_ch.ref_y   <= '0;
    end else if (!coords_ch.valid || in_taken) begin
      if (in_gap > 0) begin
        coords_ch.valid <= 1'b0;
        in_gap--;
      end else if (coord_backlog.size() == 0) begin
        coords_ch.valid <= 1'b0;
      end else if (coord_backlog.size() > CALM_TAIL && jittery &&
                   $urandom_range(0, 5) == 0) begin
        coords_ch.valid <= 1'b0;
        in_gap = $urandom_range(0, 12);
      end else begin
        c = coord_backlog.pop_front();
        coords_ch.valid   <= 1'b1;
        coords_ch.point_x <= c.px;
        coords_ch.point_y <= c.py;
        coords_ch.ref_x   <= c.rx;
        coords_ch.ref_y   <= c.ry;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      polar_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      polar_ch.ready <= 1'b0;
      out_gap--;
    end else if (coord_backlog.size() > CALM_TAIL && jittery &&
                 $urandom_range(0, 6) == 0) begin
      polar_ch.ready <= 1'b0;
      out_gap = $urandom_range(0, 12);
    end else begin
      polar_ch.ready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    coord_t c;
    polar_t want;
    bit     out_taken;
    in_taken  = !rst && coords_ch.valid && coords_ch.ready;
    out_taken = !rst && polar_ch.valid && polar_ch.ready;
    if (in_taken) begin
      c.px = coords_ch.point_x;
      c.py = coords_ch.point_y;
      c.rx = coords_ch.ref_x;
      c.ry = coords_ch.ref_y;
      pending_polar.push_back(calc_polar(c));
    end
    if (out_taken) begin
      if (pending_polar.size() == 0) begin
        $error("polar transaction with nothing expected: distance %0d angle %0d",
               polar_ch.distance, polar_ch.angle);
        fails++;
      end else begin
        want = pending_polar.pop_front();
        if (polar_ch.distance !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, polar_ch.distance);
          fails++;
        end
        if (polar_ch.angle !== want.angle) begin
          $error("angle: expected %0d, actual %0d", want.angle, polar_ch.angle);
          fails++;
        end
      end
    end
    if (rst || in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= STALL_MAX);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int                   kind;
    int                   d;
    logic signed [CW-1:0] a, b, e, f;
    rst = 1'b1;

    // zero vector, axes, quadrants, half-turn wrap, full-range extremes
    add_item(0, 0, 0, 0);
    add_item(-32768, 32767, -32768, 32767);
    add_item(1, 0, 0, 0);
    add_item(0, 1, 0, 0);
    add_item(-1, 0, 0, 0);
    add_item(0, -1, 0, 0);
    add_item(1, 1, 0, 0);
    add_item(-1, -1, 0, 0);
    add_item(-1, 1, 0, 0);
    add_item(1, -1, 0, 0);
    add_item(-32768, 5, 32767, 5);
    add_item(32767, 32767, -32768, -32768);
    add_item(-32768, -32768, 32767, 32767);
    add_item(32767, -32768, -32768, 32767);
    add_item(-32768, 32767, 32767, -32768);
    add_item(32767, 0, -32768, 0);
    add_item(0, 32767, 0, -32768);
    add_item(0, -32768, 0, 32767);
    add_item(32767, 0, -1, 0);
    add_item(-7, -3, 0, 0);
    add_item(-7, 3, 0, 0);
    add_item(3000, -1, 0, 0);
    add_item(-3000, -1, 0, 0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        a = CW'($urandom); b = CW'($urandom); e = CW'($urandom); f = CW'($urandom);
      end else if (kind < 65) begin
        e = CW'($urandom); f = CW'($urandom);
        d = $urandom_range(0, 128);
        a = e + CW'(d - 64);
        d = $urandom_range(0, 128);
        b = f + CW'(d - 64);
      end else if (kind < 80) begin
        a = corner_val(); b = corner_val(); e = corner_val(); f = corner_val();
      end else if (kind < 90) begin
        a = CW'($urandom); e = CW'($urandom); f = CW'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          b = f;
        end else begin
          b = a; a = e; e = b; b = CW'($urandom);
        end
      end else begin
        e = CW'($urandom); f = CW'($urandom);
        d = $urandom_range(0, 16383);
        a = e + CW'(($urandom_range(0, 1) == 0) ? d : -d);
        b = f + CW'(($urandom_range(0, 1) == 0) ? d : -d);
      end
      add_item(a, b, e, f);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (coord_backlog.size() == 0 && coords_ch.valid == 1'b0);
    wait (pending_polar.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
